>>> design/ullsc_pkg.sv
// Shared types and constants of the USB loss linger and shutdown controller.
package ullsc_pkg;

   // Console line store
   localparam int LINE_CAP   = 32;
   localparam int LINE_DEPTH = LINE_CAP - 1;
   localparam int LEN_W      = $clog2(LINE_CAP);
   localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   // Job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int CNT_W   = 16;
   localparam int BEAT_W  = 2;
   localparam int MAX_ECHO = 3;

   // Register reset values
   localparam logic [CNT_W-1:0] LINGER_RESET = CNT_W'(30 * 1000);
   localparam logic [CNT_W-1:0] FLASH_RESET  = CNT_W'(500);
   localparam logic [CNT_W-1:0] CHECK_RESET  = CNT_W'(1000);

   // Register indexes (byte address bits [3:2])
   localparam logic [1:0] CSR_LINGER = 2'd0;
   localparam logic [1:0] CSR_FLASH  = 2'd1;
   localparam logic [1:0] CSR_CHECK  = 2'd2;

   // Console characters
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;

   typedef enum logic [1:0] {
      KIND_TICK     = 2'd0,
      KIND_VBUS_ON  = 2'd1,
      KIND_VBUS_OFF = 2'd2,
      KIND_BYTE     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_LINGER = 2'd1,
      MODE_DOWN   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [CNT_W-1:0] linger_ms;
      logic [CNT_W-1:0] flash_half_ms;
      logic [CNT_W-1:0] usb_check_ms;
   } cfg_type;

   // One classified item: up to three result beats
   typedef struct packed {
      logic [BEAT_W-1:0]         beats;
      logic                      echo_valid;
      logic [MAX_ECHO-1:0][7:0]  echo;
      logic                      pulse;
      logic                      led;
      logic                      usb;
      logic                      shut;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> design/ullsc_front.sv
// Front end: accepts items, runs timers, power mode and line editor, emits jobs.
module ullsc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic               req_usb_level,
   input  logic [7:0]         req_rx_byte,
   input  ullsc_pkg::cfg_type   cfg,
   input  ullsc_pkg::qstat_type qstat,
   output logic               push,
   output ullsc_pkg::job_type   push_job
);
   import ullsc_pkg::*;

   mode_type         mode_ff, mode_in;
   logic             usb_ff, usb_in;
   logic             cmd_ff, cmd_in;
   logic [CNT_W-1:0] linger_cnt_ff, linger_cnt_in;
   logic [CNT_W-1:0] flash_cnt_ff, flash_cnt_in;
   logic             flashing_ff, flashing_in;
   logic             phase_ff, phase_in;
   logic             led_ff, led_in;
   logic [CNT_W-1:0] check_cnt_ff, check_cnt_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] nsc_ff, nsc_in;
   logic             nonspace_ff [LINE_DEPTH];

   logic             take;
   logic             store_we;
   logic             store_bit;
   logic [LEN_W-1:0] len_dec;
   logic [CNT_W:0]   flash_sum, linger_sum, check_sum;
   logic             pulse;

   function automatic logic [CNT_W:0] limit_of(input logic [CNT_W-1:0] v);
      return (v == '0) ? (CNT_W+1)'(1) : {1'b0, v};
   endfunction

   assign req_stall = qstat.full;
   assign take      = req_valid && !qstat.full;
   assign push      = take;
   assign len_dec   = len_ff - 1'b1;
   assign flash_sum  = {1'b0, flash_cnt_ff} + 1'b1;
   assign linger_sum = {1'b0, linger_cnt_ff} + 1'b1;
   assign check_sum  = {1'b0, check_cnt_ff} + 1'b1;

   always_comb begin
      mode_in       = mode_ff;
      usb_in        = usb_ff;
      cmd_in        = cmd_ff;
      linger_cnt_in = linger_cnt_ff;
      flash_cnt_in  = flash_cnt_ff;
      flashing_in   = flashing_ff;
      phase_in      = phase_ff;
      led_in        = led_ff;
      check_cnt_in  = check_cnt_ff;
      len_in        = len_ff;
      nsc_in        = nsc_ff;
      store_we      = 1'b0;
      store_bit     = 1'b0;
      pulse         = 1'b0;
      push_job      = '0;
      push_job.beats = BEAT_W'(1);

      if (take) begin
         unique case (kind_type'(req_kind))
            KIND_TICK: begin
               // flash timer first, then linger timer, then USB check
               if (flashing_in) begin
                  if (flash_sum >= limit_of(cfg.flash_half_ms)) begin
                     flash_cnt_in = '0;
                     phase_in     = !phase_ff;
                     led_in       = !phase_ff;
                  end else begin
                     flash_cnt_in = flash_sum[CNT_W-1:0];
                  end
               end
               if (mode_in == MODE_LINGER) begin
                  if (linger_sum >= limit_of(cfg.linger_ms)) begin
                     linger_cnt_in = '0;
                     if (usb_in && !cmd_in) begin
                        mode_in     = MODE_IDLE;
                        flashing_in = 1'b0;
                        led_in      = 1'b1;
                     end else begin
                        mode_in     = MODE_DOWN;
                        flashing_in = 1'b0;
                        led_in      = 1'b0;
                        pulse       = 1'b1;
                     end
                  end else begin
                     linger_cnt_in = linger_sum[CNT_W-1:0];
                  end
               end
               if (check_sum >= limit_of(cfg.usb_check_ms)) begin
                  check_cnt_in = '0;
                  if (req_usb_level != usb_in) begin
                     usb_in = req_usb_level;
                     if (req_usb_level) begin
                        if (mode_in == MODE_LINGER && !cmd_in) begin
                           mode_in     = MODE_IDLE;
                           flashing_in = 1'b0;
                           led_in      = 1'b1;
                        end
                     end else if (mode_in == MODE_IDLE) begin
                        mode_in       = MODE_LINGER;
                        linger_cnt_in = '0;
                        flash_cnt_in  = '0;
                        flashing_in   = 1'b1;
                        phase_in      = 1'b1;
                        led_in        = 1'b1;
                     end
                  end
               end else begin
                  check_cnt_in = check_sum[CNT_W-1:0];
               end
            end
            KIND_VBUS_ON: begin
               usb_in = 1'b1;
               if (mode_in == MODE_LINGER && !cmd_in) begin
                  mode_in     = MODE_IDLE;
                  flashing_in = 1'b0;
                  led_in      = 1'b1;
               end
            end
            KIND_VBUS_OFF: begin
               usb_in = 1'b0;
               if (mode_in == MODE_IDLE) begin
                  mode_in       = MODE_LINGER;
                  linger_cnt_in = '0;
                  flash_cnt_in  = '0;
                  flashing_in   = 1'b1;
                  phase_in      = 1'b1;
                  led_in        = 1'b1;
               end
            end
            KIND_BYTE: begin
               if (req_rx_byte == CH_BS || req_rx_byte == CH_DEL) begin
                  if (len_ff != '0) begin
                     len_in = len_dec;
                     if (nonspace_ff[len_dec[IDX_W-1:0]]) begin
                        nsc_in = nsc_ff - 1'b1;
                     end
                     push_job.beats      = BEAT_W'(3);
                     push_job.echo_valid = 1'b1;
                     push_job.echo[0]    = CH_BS;
                     push_job.echo[1]    = CH_SPACE;
                     push_job.echo[2]    = CH_BS;
                  end
               end else if (req_rx_byte == CH_LF || req_rx_byte == CH_CR) begin
                  if (len_ff != '0) begin
                     len_in = '0;
                     nsc_in = '0;
                     push_job.beats      = BEAT_W'(2);
                     push_job.echo_valid = 1'b1;
                     push_job.echo[0]    = CH_CR;
                     push_job.echo[1]    = CH_LF;
                     // a line with any non-space character starts a shutdown
                     if (nsc_ff != '0) begin
                        cmd_in = 1'b1;
                        usb_in = 1'b0;
                        if (mode_in == MODE_IDLE) begin
                           mode_in       = MODE_LINGER;
                           linger_cnt_in = '0;
                           flash_cnt_in  = '0;
                           flashing_in   = 1'b1;
                           phase_in      = 1'b1;
                           led_in        = 1'b1;
                        end
                     end
                  end
               end else if (req_rx_byte >= CH_SPACE && req_rx_byte <= CH_TILDE &&
                            len_ff < LEN_W'(LINE_DEPTH)) begin
                  store_we  = 1'b1;
                  store_bit = (req_rx_byte != CH_SPACE);
                  len_in    = len_ff + 1'b1;
                  nsc_in    = nsc_ff + LEN_W'(store_bit);
                  push_job.echo_valid = 1'b1;
                  push_job.echo[0]    = req_rx_byte;
               end
            end
         endcase
      end

      push_job.pulse = pulse;
      push_job.led   = led_in;
      push_job.usb   = usb_in;
      push_job.shut  = (mode_in != MODE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         usb_ff        <= 1'b1;
         cmd_ff        <= 1'b0;
         linger_cnt_ff <= '0;
         flash_cnt_ff  <= '0;
         flashing_ff   <= 1'b0;
         phase_ff      <= 1'b0;
         led_ff        <= 1'b1;
         check_cnt_ff  <= '0;
         len_ff        <= '0;
         nsc_ff        <= '0;
      end else begin
         mode_ff       <= mode_in;
         usb_ff        <= usb_in;
         cmd_ff        <= cmd_in;
         linger_cnt_ff <= linger_cnt_in;
         flash_cnt_ff  <= flash_cnt_in;
         flashing_ff   <= flashing_in;
         phase_ff      <= phase_in;
         led_ff        <= led_in;
         check_cnt_ff  <= check_cnt_in;
         len_ff        <= len_in;
         nsc_ff        <= nsc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         nonspace_ff[len_ff[IDX_W-1:0]] <= store_bit;
      end
   end

endmodule

>>> design/ullsc_queue.sv
// Short job queue between the front and back ends.
module ullsc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ullsc_pkg::job_type   push_job,
   input  logic                 pop,
   output ullsc_pkg::job_type   head_job,
   output ullsc_pkg::qstat_type qstat
);
   import ullsc_pkg::*;

   job_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head_job    = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> design/ullsc_back.sv
// Back end: expands each job into result beats behind an output register.
module ullsc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ullsc_pkg::job_type   head_job,
   input  ullsc_pkg::qstat_type qstat,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_echo_valid,
   output logic [7:0]           rsp_echo_byte,
   output logic                 rsp_last,
   output logic                 rsp_led_running,
   output logic                 rsp_shutdown_start,
   output logic                 rsp_usb_attached,
   output logic                 rsp_shutting_down
);
   import ullsc_pkg::*;

   logic              valid_ff, valid_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              load;
   logic              fin;

   logic              echo_valid_ff;
   logic [7:0]        echo_byte_ff;
   logic              last_ff;
   logic              led_ff;
   logic              pulse_ff;
   logic              usb_ff;
   logic              shut_ff;

   assign load = !qstat.empty && (!valid_ff || !rsp_stall);
   assign fin  = (beat_ff == head_job.beats - 1'b1);
   assign pop  = load && fin;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = fin ? '0 : beat_ff + 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   // hold the beat while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         echo_valid_ff <= head_job.echo_valid;
         echo_byte_ff  <= head_job.echo[beat_ff];
         last_ff       <= fin;
         led_ff        <= head_job.led;
         pulse_ff      <= fin && head_job.pulse;
         usb_ff        <= head_job.usb;
         shut_ff       <= head_job.shut;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_echo_valid     = echo_valid_ff;
   assign rsp_echo_byte      = echo_byte_ff;
   assign rsp_last           = last_ff;
   assign rsp_led_running    = led_ff;
   assign rsp_shutdown_start = pulse_ff;
   assign rsp_usb_attached   = usb_ff;
   assign rsp_shutting_down  = shut_ff;

endmodule

>>> design/usb_loss_linger_shutdown_controller_top.sv
// Top level of the USB loss linger and shutdown controller with its register file.
//
// channel   direction  handshake                      payload
// req       in         req_valid / req_stall          req_kind, req_usb_level, req_rx_byte
// rsp       out        rsp_valid / rsp_stall          echo, last, LED and power status
// csr       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// The front end takes one item per cycle while its four-entry job queue has room.
// The back end sends one beat per cycle from its output register while rsp is not
// stalled: an item has one to three result beats (three for a delete that removes a character).
// Reset is synchronous; there is no clearing pass.
// A stalled rsp beat holds; the queue keeps req open until it fills.
module usb_loss_linger_shutdown_controller_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic        req_usb_level,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_echo_valid,
   output logic [7:0]  rsp_echo_byte,
   output logic        rsp_last,
   output logic        rsp_led_running,
   output logic        rsp_shutdown_start,
   output logic        rsp_usb_attached,
   output logic        rsp_shutting_down,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ullsc_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      csr_write;
   logic      q_push, q_pop;
   job_type   q_push_job, q_head_job;
   qstat_type q_stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            CSR_LINGER: cfg_in.linger_ms     = pwdata[CNT_W-1:0];
            CSR_FLASH:  cfg_in.flash_half_ms = pwdata[CNT_W-1:0];
            CSR_CHECK:  cfg_in.usb_check_ms  = pwdata[CNT_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_LINGER: prdata = {{(32-CNT_W){1'b0}}, cfg_ff.linger_ms};
         CSR_FLASH:  prdata = {{(32-CNT_W){1'b0}}, cfg_ff.flash_half_ms};
         CSR_CHECK:  prdata = {{(32-CNT_W){1'b0}}, cfg_ff.usb_check_ms};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linger_ms     <= LINGER_RESET;
         cfg_ff.flash_half_ms <= FLASH_RESET;
         cfg_ff.usb_check_ms  <= CHECK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ullsc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_usb_level (req_usb_level),
      .req_rx_byte   (req_rx_byte),
      .cfg           (cfg_ff),
      .qstat         (q_stat),
      .push          (q_push),
      .push_job      (q_push_job)
   );

   ullsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .qstat    (q_stat)
   );

   ullsc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (q_head_job),
      .qstat              (q_stat),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_last           (rsp_last),
      .rsp_led_running    (rsp_led_running),
      .rsp_shutdown_start (rsp_shutdown_start),
      .rsp_usb_attached   (rsp_usb_attached),
      .rsp_shutting_down  (rsp_shutting_down)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job pushed into a full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job popped from an empty queue");

   a_pulse_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_shutdown_start |-> rsp_last && rsp_shutting_down && !rsp_led_running)
      else $error("shutdown pulse off the final beat or with wrong status");

   a_silent_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_echo_valid |-> rsp_last && rsp_echo_byte == 8'h00)
      else $error("beat without echo is not a lone zero beat");
`endif

endmodule

>>> verif/usb_loss_linger_shutdown_controller_top_tb.sv
// Self-checking testbench for the USB loss linger and shutdown controller top level.
module usb_loss_linger_shutdown_controller_top_tb;
   import ullsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic       last;
      logic       led_running;
      logic       shutdown_start;
      logic       usb_attached;
      logic       shutting_down;
   } echo_status_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic        req_usb_level;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_echo_valid;
   logic [7:0]  rsp_echo_byte;
   logic        rsp_last;
   logic        rsp_led_running;
   logic        rsp_shutdown_start;
   logic        rsp_usb_attached;
   logic        rsp_shutting_down;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Predicted state of the controller
   cfg_type               cfg_shadow;
   mode_type              power_mode;
   logic                  usb_seen;
   logic                  cmd_latched;
   logic                  flash_on;
   logic                  flash_phase;
   logic                  led_level;
   logic [CNT_W-1:0]      linger_cnt;
   logic [CNT_W-1:0]      flash_cnt;
   logic [CNT_W-1:0]      check_cnt;
   logic [LEN_W-1:0]      line_len;
   logic [LINE_DEPTH-1:0] line_nonspace;

   echo_status_type pending_echoes[$];
   echo_status_type want;
   int              mismatches = 0;
   int              items_sent = 0;
   int              beats_seen = 0;
   int              cycle_count = 0;
   int              stall_left = 0;
   int              stall_draw;
   bit              req_lazy;
   bit              rsp_lazy;

   usb_loss_linger_shutdown_controller_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_usb_level      (req_usb_level),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_echo_valid     (rsp_echo_valid),
      .rsp_echo_byte      (rsp_echo_byte),
      .rsp_last           (rsp_last),
      .rsp_led_running    (rsp_led_running),
      .rsp_shutdown_start (rsp_shutdown_start),
      .rsp_usb_attached   (rsp_usb_attached),
      .rsp_shutting_down  (rsp_shutting_down),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #1 clock = ~clock;

   function automatic bit count_mismatch();
      mismatches++;
      return mismatches <= 10;
   endfunction

   function automatic bit reached(input logic [CNT_W-1:0] count, input logic [CNT_W-1:0] limit);
      return count >= ((limit == '0) ? CNT_W'(1) : limit);
   endfunction

   function automatic bit line_has_text();
      bit found;
      found = 1'b0;
      for (int i = 0; i < LINE_DEPTH; i++)
         if (i < line_len && line_nonspace[i]) found = 1'b1;
      return found;
   endfunction

   function automatic void cancel_linger();
      power_mode = MODE_IDLE;
      flash_on   = 1'b0;
      led_level  = 1'b1;
   endfunction

   function automatic void vbus_gained();
      usb_seen = 1'b1;
      if (power_mode == MODE_LINGER && !cmd_latched) cancel_linger();
   endfunction

   function automatic void vbus_lost();
      usb_seen = 1'b0;
      if (power_mode == MODE_IDLE) begin
         // LED starts on in the first flash phase; linger and flash counts restart from zero
         power_mode  = MODE_LINGER;
         linger_cnt  = '0;
         flash_cnt   = '0;
         flash_on    = 1'b1;
         flash_phase = 1'b1;
         led_level   = 1'b1;
      end
   endfunction

   // Flash timer first, then linger timer, then USB sampling
   function automatic bit advance_tick(input logic level);
      bit pulse;
      pulse = 1'b0;
      if (flash_on) begin
         flash_cnt = flash_cnt + 1'b1;
         if (reached(flash_cnt, cfg_shadow.flash_half_ms)) begin
            flash_cnt   = '0;
            flash_phase = !flash_phase;
            led_level   = flash_phase;
         end
      end
      if (power_mode == MODE_LINGER) begin
         linger_cnt = linger_cnt + 1'b1;
         if (reached(linger_cnt, cfg_shadow.linger_ms)) begin
            linger_cnt = '0;
            if (usb_seen && !cmd_latched) begin
               cancel_linger();
            end else begin
               power_mode = MODE_DOWN;
               flash_on   = 1'b0;
               led_level  = 1'b0;
               pulse      = 1'b1;
            end
         end
      end
      check_cnt = check_cnt + 1'b1;
      if (reached(check_cnt, cfg_shadow.usb_check_ms)) begin
         check_cnt = '0;
         if (level != usb_seen) begin
            if (level) vbus_gained();
            else vbus_lost();
         end
      end
      return pulse;
   endfunction

   function automatic int edit_line(input logic [7:0] ch, output logic [2:0][7:0] seq);
      bit found;
      seq = '0;
      if (ch == CH_BS || ch == CH_DEL) begin
         if (line_len == 0) return 0;
         line_len = line_len - 1'b1;
         seq[0] = CH_BS;
         seq[1] = CH_SPACE;
         seq[2] = CH_BS;
         return 3;
      end
      if (ch == CH_LF || ch == CH_CR) begin
         if (line_len == 0) return 0;
         found    = line_has_text();
         line_len = '0;
         seq[0]   = CH_CR;
         seq[1]   = CH_LF;
         if (found) begin
            cmd_latched = 1'b1;
            vbus_lost();
         end
         return 2;
      end
      if (ch >= CH_SPACE && ch <= CH_TILDE && line_len < LINE_DEPTH) begin
         line_nonspace[line_len] = (ch != CH_SPACE);
         line_len = line_len + 1'b1;
         seq[0]   = ch;
         return 1;
      end
      return 0;
   endfunction

   function automatic void predict_item(input kind_type kind, input logic level,
                                        input logic [7:0] ch);
      logic [2:0][7:0] seq;
      int              n_echo;
      int              n;
      bit              pulse;
      echo_status_type beat;
      seq    = '0;
      n_echo = 0;
      pulse  = 1'b0;
      case (kind)
         KIND_TICK:     pulse = advance_tick(level);
         KIND_VBUS_ON:  vbus_gained();
         KIND_VBUS_OFF: vbus_lost();
         default:       n_echo = edit_line(ch, seq);
      endcase
      n = (n_echo > 0) ? n_echo : 1;
      for (int k = 0; k < n; k++) begin
         beat.echo_valid     = (n_echo > 0);
         beat.echo_byte      = (n_echo > 0) ? seq[k] : 8'h00;
         beat.last           = (k == n - 1);
         beat.led_running    = led_level;
         beat.shutdown_start = (k == n - 1) && pulse;
         beat.usb_attached   = usb_seen;
         beat.shutting_down  = (power_mode != MODE_IDLE);
         pending_echoes.push_back(beat);
      end
   endfunction

   // Result side: while rsp_lazy is set, draw a random stall after each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_valid && !rsp_stall && rsp_lazy) begin
         stall_draw = $urandom_range(0, 3);
         rsp_stall  <= (stall_draw != 0);
         stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_echoes.size() == 0) begin
            if (count_mismatch())
               $display("beat %0d: no result pending, got echo %0b/%02h", beats_seen,
                        rsp_echo_valid, rsp_echo_byte);
         end else begin
            want = pending_echoes.pop_front();
            if (rsp_echo_valid !== want.echo_valid || rsp_echo_byte !== want.echo_byte ||
                rsp_last !== want.last || rsp_led_running !== want.led_running ||
                rsp_shutdown_start !== want.shutdown_start ||
                rsp_usb_attached !== want.usb_attached ||
                rsp_shutting_down !== want.shutting_down) begin
               if (count_mismatch()) begin
                  $display("beat %0d exp: ev=%0b b=%02h l=%0b led=%0b p=%0b usb=%0b sd=%0b",
                           beats_seen, want.echo_valid, want.echo_byte, want.last,
                           want.led_running, want.shutdown_start, want.usb_attached,
                           want.shutting_down);
                  $display("beat %0d got: ev=%0b b=%02h l=%0b led=%0b p=%0b usb=%0b sd=%0b",
                           beats_seen, rsp_echo_valid, rsp_echo_byte, rsp_last,
                           rsp_led_running, rsp_shutdown_start, rsp_usb_attached,
                           rsp_shutting_down);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("usb_loss_linger_shutdown_controller_top verification failed");
         $finish;
      end
   end

   task automatic send_item(input kind_type kind, input logic level, input logic [7:0] ch);
      int gap;
      gap = req_lazy ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_usb_level <= level;
      req_rx_byte   <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(kind, level, ch);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_echoes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CNT_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         CSR_LINGER: cfg_shadow.linger_ms     = value;
         CSR_FLASH:  cfg_shadow.flash_half_ms = value;
         CSR_CHECK:  cfg_shadow.usb_check_ms  = value;
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      // read back
      psel <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[CNT_W-1:0] !== value && count_mismatch())
         $display("register %0d: expected %04h, read %04h", idx, value, prdata[CNT_W-1:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timers(input logic [CNT_W-1:0] linger, input logic [CNT_W-1:0] flash,
                             input logic [CNT_W-1:0] check);
      drain_results();
      csr_write(CSR_LINGER, linger);
      csr_write(CSR_FLASH, flash);
      csr_write(CSR_CHECK, check);
   endtask

   function automatic logic [7:0] delete_char();
      return $urandom_range(0, 1) ? CH_BS : CH_DEL;
   endfunction

   // Mostly agree with the believed USB state so lingers stay short
   function automatic logic pick_level();
      return ($urandom_range(0, 5) == 0) ? !usb_seen : usb_seen;
   endfunction

   function automatic logic [7:0] noise_byte(input bit allow_cmd);
      logic [7:0] ch;
      ch = 8'($urandom);
      if (!allow_cmd && (ch == CH_CR || ch == CH_LF) && line_has_text()) ch = CH_DEL;
      return ch;
   endfunction

   // Type a line, maybe with corrections, then press Enter
   task automatic console_line(input bit allow_cmd);
      int         len;
      logic [7:0] ch;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 6);
      repeat (len) begin
         ch = ($urandom_range(0, 2) == 0) ? CH_SPACE : 8'($urandom_range(33, 126));
         send_item(KIND_BYTE, 1'($urandom), ch);
         if ($urandom_range(0, 5) == 0) send_item(KIND_BYTE, 1'($urandom), delete_char());
      end
      if (!allow_cmd || $urandom_range(0, 1))
         while (line_has_text()) send_item(KIND_BYTE, 1'($urandom), delete_char());
      send_item(KIND_BYTE, 1'($urandom), $urandom_range(0, 1) ? CH_CR : CH_LF);
   endtask

   task automatic random_traffic(input int count, input bit allow_cmd);
      int stop_at;
      int pick;
      int rounds;
      stop_at = items_sent + count;
      rounds  = 0;
      while (items_sent < stop_at) begin
         if (rounds % 16 == 0) begin
            req_lazy = ($urandom_range(0, 3) != 0);
            rsp_lazy = ($urandom_range(0, 3) != 0);
         end
         rounds++;
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_item(KIND_TICK, pick_level(), 8'($urandom));
         else if (pick < 57)
            send_item(KIND_VBUS_ON, 1'($urandom), 8'($urandom));
         else if (pick < 65)
            send_item(KIND_VBUS_OFF, 1'($urandom), 8'($urandom));
         else if (pick < 88)
            console_line(allow_cmd);
         else
            send_item(KIND_BYTE, 1'($urandom), noise_byte(allow_cmd));
      end
   endtask

   task automatic test_directed();
      send_item(KIND_TICK, 1'b1, 8'h00);
      send_item(KIND_VBUS_ON, 1'b0, 8'hFF);
      send_item(KIND_BYTE, 1'b0, CH_BS);
      send_item(KIND_BYTE, 1'b1, CH_DEL);
      send_item(KIND_BYTE, 1'b0, CH_LF);
      send_item(KIND_BYTE, 1'b0, CH_CR);
      send_item(KIND_BYTE, 1'b0, 8'h00);
      send_item(KIND_BYTE, 1'b0, 8'h1F);
      send_item(KIND_BYTE, 1'b0, 8'h80);
      send_item(KIND_BYTE, 1'b0, 8'hFF);
      send_item(KIND_BYTE, 1'b0, CH_SPACE);
      send_item(KIND_BYTE, 1'b0, CH_TILDE);
      send_item(KIND_BYTE, 1'b0, CH_DEL);
      // blank line ends without a shutdown
      send_item(KIND_BYTE, 1'b0, CH_CR);
      send_item(KIND_BYTE, 1'b0, 8'h41);
      send_item(KIND_BYTE, 1'b0, CH_BS);
      send_item(KIND_BYTE, 1'b0, CH_LF);
      send_item(KIND_VBUS_OFF, 1'b1, 8'h00);
      send_item(KIND_TICK, 1'b0, 8'h00);
      send_item(KIND_VBUS_OFF, 1'b0, 8'h00);
      send_item(KIND_VBUS_ON, 1'b1, 8'h00);
      send_item(KIND_TICK, 1'b0, 8'hFF);
   endtask

   task automatic test_slow_timers();
      set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_traffic(40, 1'b0);
   endtask

   task automatic test_fast_flash();
      set_timers(16'd40, 16'd1, 16'd1);
      random_traffic(40, 1'b0);
      // hold off until every result is back
      drain_results();
      random_traffic(40, 1'b0);
   endtask

   task automatic test_mid_rates();
      set_timers(16'd30, 16'd3, 16'd5);
      random_traffic(80, 1'b0);
   endtask

   task automatic test_command_shutdown();
      set_timers(16'd1, 16'd2, 16'd3);
      req_lazy = 1'b1;
      rsp_lazy = 1'b1;
      while (line_len != 0) send_item(KIND_BYTE, 1'b0, delete_char());
      send_item(KIND_BYTE, 1'b0, 8'h6F);
      send_item(KIND_BYTE, 1'b0, 8'h6B);
      send_item(KIND_BYTE, 1'b0, CH_CR);
      // command-started linger survives USB coming back
      send_item(KIND_VBUS_ON, 1'b1, 8'h00);
      send_item(KIND_TICK, 1'b1, 8'h00);
      send_item(KIND_VBUS_OFF, 1'b0, 8'h00);
      send_item(KIND_VBUS_ON, 1'b1, 8'h00);
      send_item(KIND_TICK, 1'b0, 8'h00);
      send_item(KIND_BYTE, 1'b0, 8'h78);
      random_traffic(60, 1'b1);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_TICK;
      req_usb_level = 1'b0;
      req_rx_byte   = 8'h00;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_lazy      = 1'b1;
      rsp_lazy      = 1'b1;
      cfg_shadow    = '{linger_ms: LINGER_RESET, flash_half_ms: FLASH_RESET,
                        usb_check_ms: CHECK_RESET};
      power_mode    = MODE_IDLE;
      usb_seen      = 1'b1;
      cmd_latched   = 1'b0;
      flash_on      = 1'b0;
      flash_phase   = 1'b0;
      led_level     = 1'b1;
      linger_cnt    = '0;
      flash_cnt     = '0;
      check_cnt     = '0;
      line_len      = '0;
      line_nonspace = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_slow_timers();
      test_fast_flash();
      test_mid_rates();
      test_command_shutdown();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("usb_loss_linger_shutdown_controller_top verification clean");
      else
         $display("usb_loss_linger_shutdown_controller_top verification failed");
      $finish;
   end

endmodule
